@@ rtl/sps_pkg.sv @@
// ----------------------------------------------------------------------------
// Segment path steering package
// Shared widths, codes, state type and the tangent table of the steering unit.
// ----------------------------------------------------------------------------
package sps_pkg;

   localparam int COORD_W   = 16;
   localparam int DIFF_W    = 17;
   localparam int SUM_W     = 18;
   localparam int SQ_W      = 36;
   localparam int TGT_W     = 56;
   localparam int MAG_W     = 52;
   localparam int NORM_W    = 31;
   localparam int DEG_W     = 9;
   localparam int STATUS_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam int MUL_A_W = 56;
   localparam int MUL_B_W = 32;
   localparam int MUL_P_W = 64;

   localparam int STOP_RADIUS_DEF   = 400;
   localparam int ARRIVE_RADIUS_DEF = 100;

   localparam int        TAN_COUNT  = 44;
   localparam int        TAN_IDX_W  = 6;
   localparam int        TAN_W      = 30;
   localparam logic [29:0] TAN_SCALE = 30'd1000000000;

   localparam logic [DEG_W-1:0] SPEED_STOP   = 9'd0;
   localparam logic [DEG_W-1:0] SPEED_CRUISE = 9'd300;
   localparam logic [DEG_W-1:0] SPEED_PASS   = 9'd500;

   localparam logic [DEG_W-1:0] DIR_FULL  = 9'd360;
   localparam logic [DEG_W-1:0] DIR_HALF  = 9'd180;
   localparam logic [DEG_W-1:0] DIR_UP    = 9'd89;
   localparam logic [DEG_W-1:0] DIR_DOWN  = 9'd270;
   localparam logic [6:0]       DEG_EIGHTH = 7'd45;
   localparam logic [6:0]       DEG_NEAR_RIGHT = 7'd89;

   localparam logic [STATUS_W-1:0] ST_MOVING   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_REACHING = 2'd1;
   localparam logic [STATUS_W-1:0] ST_STOPPED  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_START_X    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PASS       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_X = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_Y = 3'd6;

   localparam logic signed [COORD_W-1:0] OBSTACLE_RESET = 16'sd2643;

   // Multiply operations issued by the sequencer, in order.
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_OX  = 4'd0;
   localparam logic [OP_W-1:0] OP_OY  = 4'd1;
   localparam logic [OP_W-1:0] OP_BX  = 4'd2;
   localparam logic [OP_W-1:0] OP_BY  = 4'd3;
   localparam logic [OP_W-1:0] OP_DX  = 4'd4;
   localparam logic [OP_W-1:0] OP_DY  = 4'd5;
   localparam logic [OP_W-1:0] OP_NX  = 4'd6;
   localparam logic [OP_W-1:0] OP_NY  = 4'd7;
   localparam logic [OP_W-1:0] OP_TX0 = 4'd8;
   localparam logic [OP_W-1:0] OP_TX1 = 4'd9;
   localparam logic [OP_W-1:0] OP_TY0 = 4'd10;
   localparam logic [OP_W-1:0] OP_TY1 = 4'd11;
   localparam logic [OP_W-1:0] OP_Q   = 4'd12;
   localparam logic [OP_W-1:0] OP_TAB = 4'd13;

   typedef enum logic [1:0] {
      CLS_ZERO_Y = 2'd0,
      CLS_DIAG   = 2'd1,
      CLS_LOW    = 2'd2,
      CLS_HIGH   = 2'd3
   } class_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_GO,
      S_WAIT,
      S_CLASS,
      S_NORM,
      S_DIR,
      S_OUT
   } state_type;

   function automatic logic [TAN_W-1:0] tan_e9(input logic [TAN_IDX_W-1:0] k);
      logic [TAN_W-1:0] t;
      unique case (k)
         6'd0:  t = 30'd17455065;   6'd1:  t = 30'd34920769;
         6'd2:  t = 30'd52407779;   6'd3:  t = 30'd69926812;
         6'd4:  t = 30'd87488664;   6'd5:  t = 30'd105104235;
         6'd6:  t = 30'd122784561;  6'd7:  t = 30'd140540835;
         6'd8:  t = 30'd158384440;  6'd9:  t = 30'd176326981;
         6'd10: t = 30'd194380309;  6'd11: t = 30'd212556562;
         6'd12: t = 30'd230868191;  6'd13: t = 30'd249328003;
         6'd14: t = 30'd267949192;  6'd15: t = 30'd286745386;
         6'd16: t = 30'd305730681;  6'd17: t = 30'd324919696;
         6'd18: t = 30'd344327613;  6'd19: t = 30'd363970234;
         6'd20: t = 30'd383864035;  6'd21: t = 30'd404026226;
         6'd22: t = 30'd424474816;  6'd23: t = 30'd445228685;
         6'd24: t = 30'd466307658;  6'd25: t = 30'd487732589;
         6'd26: t = 30'd509525449;  6'd27: t = 30'd531709432;
         6'd28: t = 30'd554309051;  6'd29: t = 30'd577350269;
         6'd30: t = 30'd600860619;  6'd31: t = 30'd624869352;
         6'd32: t = 30'd649407593;  6'd33: t = 30'd674508517;
         6'd34: t = 30'd700207538;  6'd35: t = 30'd726542528;
         6'd36: t = 30'd753554050;  6'd37: t = 30'd781285627;
         6'd38: t = 30'd809784033;  6'd39: t = 30'd839099631;
         6'd40: t = 30'd869286738;  6'd41: t = 30'd900404044;
         6'd42: t = 30'd932515086;  6'd43: t = 30'd965688775;
         default: t = '1;
      endcase
      return t;
   endfunction

endpackage

@@ rtl/sps_if.sv @@
// ----------------------------------------------------------------------------
// Segment path steering channels
// Request channel (position update) and response channel (drive command).
// ----------------------------------------------------------------------------
interface sps_req_if;
   logic                valid;
   logic                ready;
   logic signed [15:0]  pos_x;
   logic signed [15:0]  pos_y;
   logic [8:0]          heading;

   modport source (output valid, pos_x, pos_y, heading, input ready);
   modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface sps_rsp_if;
   logic       valid;
   logic       ready;
   logic [8:0] speed_cmd;
   logic [8:0] direction_deg;
   logic [8:0] heading_out;
   logic       drive_enable;
   logic [1:0] path_status;

   modport source (output valid, speed_cmd, direction_deg, heading_out, drive_enable,
                   path_status, input ready);
   modport sink   (input valid, speed_cmd, direction_deg, heading_out, drive_enable,
                   path_status, output ready);
endinterface

@@ rtl/sps_serial_mul.sv @@
// ----------------------------------------------------------------------------
// Bit-serial signed multiplier
// Shift-and-add over one multiplier bit per cycle; the top bit is subtracted.
// ----------------------------------------------------------------------------
module sps_serial_mul
   import sps_pkg::*;
#(
   parameter int AW = MUL_A_W,
   parameter int BW = MUL_B_W,
   parameter int PW = MUL_P_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [AW-1:0] op_a,
   input  logic signed [BW-1:0] op_b,
   output logic                 done,
   output logic signed [PW-1:0] product
);

   localparam int CW = $clog2(BW);

   logic signed [PW-1:0] acc_ff;
   logic signed [PW-1:0] mcand_ff;
   logic [BW-1:0]        mplier_ff;
   logic [CW-1:0]        cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic                 last_bit;

   assign last_bit = (cnt_ff == CW'(BW - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && last_bit) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff    <= '0;
         mcand_ff  <= PW'(op_a);
         mplier_ff <= op_b;
         cnt_ff    <= '0;
      end else if (busy_ff) begin
         // The sign bit of the multiplier carries negative weight.
         if (mplier_ff[0]) begin
            acc_ff <= last_bit ? acc_ff - mcand_ff : acc_ff + mcand_ff;
         end
         mcand_ff  <= mcand_ff <<< 1;
         mplier_ff <= mplier_ff >> 1;
         cnt_ff    <= cnt_ff + 1'b1;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("multiplier done while still busy");
   assert property (@(posedge clock) disable iff (reset) start |=> busy_ff)
      else $error("multiplier did not start");
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("multiplier done longer than one cycle");

endmodule

@@ rtl/segment_path_steering_unit.sv @@
// Sequence: an obstacle stop ends after the obstacle distance, a segment-end command
// after the end distance, and a cruise command takes up to 19 serial multiplies
// plus up to 21 normalizing shifts.
// The unit handles one item at a time; the next request is taken in the cycle after the
// command is queued, so an item holds the unit through any output stall until then.
// Reset (synchronous, active high) clears the registers to their reset values
// and the state machine to idle.
// ----------------------------------------------------------------------------
// Segment path steering unit
// Turns a position update into a stop, pass-through or cruise drive command.
// ----------------------------------------------------------------------------
module segment_path_steering_unit
   import sps_pkg::*;
#(
   parameter int STOP_RADIUS   = STOP_RADIUS_DEF,
   parameter int ARRIVE_RADIUS = ARRIVE_RADIUS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   sps_req_if.sink              req_if,
   sps_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]   csr_wdata
);

   localparam logic signed [SQ_W-1:0] STOP_SQ   = SQ_W'(STOP_RADIUS * STOP_RADIUS);
   localparam logic signed [SQ_W-1:0] ARRIVE_SQ = SQ_W'(ARRIVE_RADIUS * ARRIVE_RADIUS);

   // Configuration registers
   logic signed [COORD_W-1:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic signed [COORD_W-1:0] obstacle_x_ff, obstacle_y_ff;
   logic                      pass_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff    <= '0;
         start_y_ff    <= '0;
         end_x_ff      <= '0;
         end_y_ff      <= '0;
         pass_ff       <= 1'b0;
         obstacle_x_ff <= OBSTACLE_RESET;
         obstacle_y_ff <= OBSTACLE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_START_X:    start_x_ff    <= csr_wdata;
            CSR_START_Y:    start_y_ff    <= csr_wdata;
            CSR_END_X:      end_x_ff      <= csr_wdata;
            CSR_END_Y:      end_y_ff      <= csr_wdata;
            CSR_PASS:       pass_ff       <= csr_wdata[0];
            CSR_OBSTACLE_X: obstacle_x_ff <= csr_wdata;
            CSR_OBSTACLE_Y: obstacle_y_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer state and datapath
   state_type state_ff, state_in;
   logic [OP_W-1:0]             op_ff;
   logic signed [DIFF_W-1:0]    ox_ff, oy_ff, bx_ff, by_ff, dx_ff, dy_ff, ex_ff, ey_ff;
   logic signed [SUM_W-1:0]     axn_ff, ayn_ff, sx_ff, sy_ff;
   logic signed [SQ_W-1:0]      sq_ff, dd_ff, nn_ff;
   logic signed [TGT_W-1:0]     tx_ff, ty_ff;
   logic [MAG_W-1:0]            s_ff, l_ff;
   logic [DEG_W-1:0]            heading_ff;
   class_type                   cls_ff;
   logic [TAN_IDX_W-1:0]        lo_ff, hi_ff;
   logic signed [MUL_P_W-1:0]   q_ff;
   logic [DEG_W-1:0]            last_dir_ff;
   logic [STATUS_W-1:0]         status_ff;

   logic [DEG_W-1:0]            p_speed_ff, p_dir_ff, p_head_ff;
   logic                        p_en_ff;
   logic [STATUS_W-1:0]         p_stat_ff;

   logic                        rsp_valid_ff;
   logic [DEG_W-1:0]            r_speed_ff, r_dir_ff, r_head_ff;
   logic                        r_en_ff;
   logic [STATUS_W-1:0]         r_stat_ff;

   // Multiplier
   logic                        mul_start, mul_done;
   logic signed [MUL_A_W-1:0]   mul_a;
   logic signed [MUL_B_W-1:0]   mul_b;
   logic signed [MUL_P_W-1:0]   mul_p;

   sps_serial_mul #(.AW(MUL_A_W), .BW(MUL_B_W), .PW(MUL_P_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   logic [TAN_IDX_W-1:0] mid;
   assign mid = TAN_IDX_W'((7'(lo_ff) + 7'(hi_ff)) >> 1);

   always_comb begin
      case (op_ff)
         OP_OX:   begin mul_a = MUL_A_W'(ox_ff);  mul_b = MUL_B_W'(ox_ff); end
         OP_OY:   begin mul_a = MUL_A_W'(oy_ff);  mul_b = MUL_B_W'(oy_ff); end
         OP_BX:   begin mul_a = MUL_A_W'(bx_ff);  mul_b = MUL_B_W'(bx_ff); end
         OP_BY:   begin mul_a = MUL_A_W'(by_ff);  mul_b = MUL_B_W'(by_ff); end
         OP_DX:   begin mul_a = MUL_A_W'(dx_ff);  mul_b = MUL_B_W'(dx_ff); end
         OP_DY:   begin mul_a = MUL_A_W'(dy_ff);  mul_b = MUL_B_W'(dy_ff); end
         OP_NX:   begin mul_a = MUL_A_W'(axn_ff); mul_b = MUL_B_W'(dx_ff); end
         OP_NY:   begin mul_a = MUL_A_W'(ayn_ff); mul_b = MUL_B_W'(dy_ff); end
         OP_TX0:  begin mul_a = MUL_A_W'(dd_ff);  mul_b = MUL_B_W'(sx_ff); end
         OP_TX1:  begin mul_a = MUL_A_W'(nn_ff);  mul_b = MUL_B_W'(ex_ff); end
         OP_TY0:  begin mul_a = MUL_A_W'(dd_ff);  mul_b = MUL_B_W'(sy_ff); end
         OP_TY1:  begin mul_a = MUL_A_W'(nn_ff);  mul_b = MUL_B_W'(ey_ff); end
         OP_Q: begin
            mul_a = {{(MUL_A_W-MAG_W){1'b0}}, s_ff};
            mul_b = {{(MUL_B_W-TAN_W){1'b0}}, TAN_SCALE};
         end
         default: begin
            mul_a = {{(MUL_A_W-MAG_W){1'b0}}, l_ff};
            mul_b = {{(MUL_B_W-TAN_W){1'b0}}, tan_e9(mid)};
         end
      endcase
   end

   assign mul_start = (state_ff == S_GO);

   logic signed [SQ_W-1:0] sq_sum;
   logic                   near_obstacle, at_end, tab_hit, out_free;
   assign sq_sum        = sq_ff + SQ_W'(mul_p);
   assign near_obstacle = (sq_sum <= STOP_SQ);
   assign at_end        = (sq_sum < ARRIVE_SQ);
   assign tab_hit       = (q_ff >= mul_p);
   assign out_free      = !rsp_valid_ff || rsp_if.ready;

   // Magnitudes of the aim vector
   logic [MAG_W-1:0] ax_mag, ay_mag;
   assign ax_mag = MAG_W'(tx_ff[TGT_W-1] ? -tx_ff : tx_ff);
   assign ay_mag = MAG_W'(ty_ff[TGT_W-1] ? -ty_ff : ty_ff);

   // Direction from the counted tangent steps
   logic [6:0]       fl, cl;
   logic [DEG_W-1:0] dir_val;
   always_comb begin
      unique case (cls_ff)
         CLS_ZERO_Y: fl = '0;
         CLS_DIAG:   fl = DEG_EIGHTH;
         CLS_LOW:    fl = 7'(lo_ff);
         default:    fl = DEG_NEAR_RIGHT - 7'(lo_ff);
      endcase
      cl = (cls_ff == CLS_ZERO_Y || cls_ff == CLS_DIAG) ? fl : fl + 7'd1;
      if (tx_ff == '0) begin
         if (ty_ff > 0)      dir_val = DIR_UP;
         else if (ty_ff < 0) dir_val = DIR_DOWN;
         else                dir_val = DIR_FULL;
      end else if (!tx_ff[TGT_W-1]) begin
         if (ty_ff > 0)       dir_val = DEG_W'(fl);
         else if (ty_ff == 0) dir_val = DIR_FULL;
         else                 dir_val = DIR_FULL - DEG_W'(cl);
      end else begin
         if (!ty_ff[TGT_W-1]) dir_val = DIR_HALF - DEG_W'(cl);
         else                 dir_val = DIR_HALF + DEG_W'(fl);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in     = state_ff;
      req_if.ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) state_in = S_GO;
         end
         S_GO: state_in = S_WAIT;
         S_WAIT: begin
            if (mul_done) begin
               case (op_ff)
                  OP_OY:  state_in = near_obstacle ? S_OUT : S_GO;
                  OP_BY:  state_in = at_end ? S_OUT : S_GO;
                  OP_TY1: state_in = S_CLASS;
                  OP_Q:   state_in = S_GO;
                  OP_TAB: begin
                     if ((tab_hit ? mid + 1'b1 : lo_ff) == (tab_hit ? hi_ff : mid))
                        state_in = S_DIR;
                     else
                        state_in = S_GO;
                  end
                  default: state_in = S_GO;
               endcase
            end
         end
         S_CLASS: begin
            if (tx_ff == '0 || ay_mag == '0 || ay_mag == ax_mag) state_in = S_DIR;
            else                                                state_in = S_NORM;
         end
         S_NORM: if (l_ff[MAG_W-1:NORM_W] == '0) state_in = S_GO;
         S_DIR:  state_in = S_OUT;
         S_OUT:  if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath registers
   logic signed [DIFF_W-1:0] mx_w, my_w, ex_w, ey_w;
   assign mx_w = DIFF_W'(start_x_ff) - DIFF_W'(req_if.pos_x);
   assign my_w = DIFF_W'(start_y_ff) - DIFF_W'(req_if.pos_y);
   assign ex_w = DIFF_W'(end_x_ff) - DIFF_W'(start_x_ff);
   assign ey_w = DIFF_W'(end_y_ff) - DIFF_W'(start_y_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         last_dir_ff <= '0;
         status_ff   <= ST_MOVING;
      end else if (state_ff == S_WAIT && mul_done) begin
         if (op_ff == OP_BY && at_end) begin
            status_ff <= pass_ff ? ST_REACHING : ST_STOPPED;
         end
      end else if (state_ff == S_DIR) begin
         last_dir_ff <= dir_val;
         status_ff   <= ST_MOVING;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            op_ff      <= OP_OX;
            heading_ff <= req_if.heading;
            ox_ff  <= DIFF_W'(obstacle_x_ff) - DIFF_W'(req_if.pos_x);
            oy_ff  <= DIFF_W'(obstacle_y_ff) - DIFF_W'(req_if.pos_y);
            bx_ff  <= DIFF_W'(end_x_ff) - DIFF_W'(req_if.pos_x);
            by_ff  <= DIFF_W'(end_y_ff) - DIFF_W'(req_if.pos_y);
            ex_ff  <= ex_w;
            ey_ff  <= ey_w;
            // A zero-length axis gets the unit nudge.
            dx_ff  <= (ex_w == '0) ? -DIFF_W'(1) : ex_w;
            dy_ff  <= (ey_w == '0) ? -DIFF_W'(1) : ey_w;
            axn_ff <= SUM_W'(mx_w) + ((ex_w == '0) ? SUM_W'(1) : SUM_W'(0));
            ayn_ff <= SUM_W'(my_w) + ((ey_w == '0) ? SUM_W'(1) : SUM_W'(0));
            sx_ff  <= SUM_W'(mx_w) + SUM_W'(DIFF_W'(end_x_ff) - DIFF_W'(req_if.pos_x));
            sy_ff  <= SUM_W'(my_w) + SUM_W'(DIFF_W'(end_y_ff) - DIFF_W'(req_if.pos_y));
            lo_ff  <= '0;
            hi_ff  <= TAN_IDX_W'(TAN_COUNT);
         end
         S_WAIT: begin
            if (mul_done) begin
               op_ff <= op_ff + 1'b1;
               case (op_ff) inside
                  OP_OX, OP_BX: sq_ff <= SQ_W'(mul_p);
                  OP_OY: begin
                     p_speed_ff <= SPEED_STOP; p_dir_ff <= '0; p_head_ff <= '0;
                     p_en_ff    <= 1'b0;       p_stat_ff <= status_ff;
                  end
                  OP_BY: begin
                     if (pass_ff) begin
                        p_speed_ff <= SPEED_PASS; p_dir_ff <= last_dir_ff;
                        p_head_ff  <= heading_ff; p_en_ff <= 1'b1;
                        p_stat_ff  <= ST_REACHING;
                     end else begin
                        p_speed_ff <= SPEED_STOP; p_dir_ff <= '0; p_head_ff <= '0;
                        p_en_ff    <= 1'b0;       p_stat_ff <= ST_STOPPED;
                     end
                  end
                  OP_DX:  dd_ff <= SQ_W'(mul_p);
                  OP_DY:  dd_ff <= dd_ff + SQ_W'(mul_p);
                  OP_NX:  nn_ff <= SQ_W'(mul_p);
                  OP_NY:  nn_ff <= nn_ff + SQ_W'(mul_p);
                  OP_TX0: tx_ff <= TGT_W'(mul_p);
                  OP_TX1: tx_ff <= tx_ff - TGT_W'(mul_p);
                  OP_TY0: ty_ff <= TGT_W'(mul_p);
                  OP_TY1: ty_ff <= ty_ff - TGT_W'(mul_p);
                  OP_Q:   q_ff  <= mul_p;
                  default: begin
                     op_ff <= OP_TAB;
                     if (tab_hit) lo_ff <= mid + 1'b1;
                     else         hi_ff <= mid;
                  end
               endcase
            end
         end
         S_CLASS: begin
            op_ff <= OP_Q;
            if (ay_mag == '0) begin
               cls_ff <= CLS_ZERO_Y;
            end else if (ay_mag == ax_mag) begin
               cls_ff <= CLS_DIAG;
            end else if (ay_mag < ax_mag) begin
               cls_ff <= CLS_LOW;  s_ff <= ay_mag; l_ff <= ax_mag;
            end else begin
               cls_ff <= CLS_HIGH; s_ff <= ax_mag; l_ff <= ay_mag;
            end
         end
         S_NORM: begin
            // One bit per cycle until the larger magnitude fits the table compare.
            if (l_ff[MAG_W-1:NORM_W] != '0) begin
               s_ff <= s_ff >> 1;
               l_ff <= l_ff >> 1;
            end
         end
         S_DIR: begin
            p_speed_ff <= SPEED_CRUISE; p_dir_ff <= dir_val; p_head_ff <= heading_ff;
            p_en_ff    <= 1'b1;         p_stat_ff <= ST_MOVING;
         end
         default: ;
      endcase
   end

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         r_speed_ff <= p_speed_ff;
         r_dir_ff   <= p_dir_ff;
         r_head_ff  <= p_head_ff;
         r_en_ff    <= p_en_ff;
         r_stat_ff  <= p_stat_ff;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.speed_cmd     = r_speed_ff;
   assign rsp_if.direction_deg = r_dir_ff;
   assign rsp_if.heading_out   = r_head_ff;
   assign rsp_if.drive_enable  = r_en_ff;
   assign rsp_if.path_status   = r_stat_ff;

   assert property (@(posedge clock) disable iff (reset) lo_ff <= hi_ff)
      else $error("tangent search bounds crossed");
   assert property (@(posedge clock) disable iff (reset) mul_done |-> state_ff == S_WAIT)
      else $error("multiply finished outside the wait state");
   assert property (@(posedge clock) disable iff (reset)
                    state_ff == S_OUT && out_free |=> state_ff == S_IDLE && rsp_valid_ff)
      else $error("command not queued at the end of an item");
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && !r_en_ff |-> r_speed_ff == SPEED_STOP)
      else $error("stop command with nonzero speed");

endmodule

@@ tb/segment_path_steering_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment path steering unit testbench
// Drives position updates through the steering unit under several segment,
// obstacle and pass-through settings. A built-in predictor computes every
// drive command and the monitor compares each response field by field.
// ----------------------------------------------------------------------------
module segment_path_steering_unit_test;
   import sps_pkg::*;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [8:0]         heading;
   } position_type;

   typedef struct packed {
      logic [8:0] speed_cmd;
      logic [8:0] direction_deg;
      logic [8:0] heading_out;
      logic       drive_enable;
      logic [1:0] path_status;
   } command_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam longint TAN_TABLE [44] = '{
      17455065, 34920769, 52407779, 69926812, 87488664,
      105104235, 122784561, 140540835, 158384440, 176326981,
      194380309, 212556562, 230868191, 249328003, 267949192,
      286745386, 305730681, 324919696, 344327613, 363970234,
      383864035, 404026226, 424474816, 445228685, 466307658,
      487732589, 509525449, 531709432, 554309051, 577350269,
      600860619, 624869352, 649407593, 674508517, 700207538,
      726542528, 753554050, 781285627, 809784033, 839099631,
      869286738, 900404044, 932515086, 965688775};

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0] csr_wdata;

   sps_req_if req_if ();
   sps_rsp_if rsp_if ();

   segment_path_steering_unit dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor copy of the registers and state.
   longint seg_sx, seg_sy, seg_ex, seg_ey, obs_x, obs_y;
   bit pass_mode;
   logic [8:0] last_dir;
   logic [1:0] status_q;

   position_type pending_positions[$];
   command_type expected_commands[$];
   int error_count;
   int commands_seen;
   int idle_cycles;
   bit drive_calm;
   int hold_off_cycles;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch on command %0d: %s got %0d expected %0d",
               commands_seen, what, got, want);
      error_count++;
   endtask

   function automatic int count_tangents(longint s, longint l);
      int c;
      c = 0;
      while ((l >>> 31) != 0) begin
         s = s >>> 1;
         l = l >>> 1;
      end
      for (int k = 0; k < 44; k++)
         if (s * 1000000000 >= l * TAN_TABLE[k]) c++;
      return c;
   endfunction

   function automatic logic [8:0] aim_heading(longint tx, longint ty);
      longint ax, ay;
      int fl, cl;
      bit exact;
      if (tx == 0) return ty > 0 ? DIR_UP : (ty < 0 ? DIR_DOWN : DIR_FULL);
      ax = tx < 0 ? -tx : tx;
      ay = ty < 0 ? -ty : ty;
      exact = 1'b0;
      if (ay == 0) begin
         fl = 0; exact = 1'b1;
      end else if (ay == ax) begin
         fl = 45; exact = 1'b1;
      end else if (ay < ax) fl = count_tangents(ay, ax);
      else fl = 89 - count_tangents(ax, ay);
      cl = fl + (exact ? 0 : 1);
      if (tx > 0) begin
         if (ty > 0) return 9'(fl);
         if (ty == 0) return DIR_FULL;
         return 9'(360 - cl);
      end
      if (ty >= 0) return 9'(180 - cl);
      return 9'(180 + fl);
   endfunction

   function automatic command_type steer(position_type p);
      command_type c;
      longint px, py, ox, oy, bx, by, mx, my, ex, ey, an, bn, dx, dy, dd, nn;
      px = p.pos_x; py = p.pos_y;
      ox = obs_x - px; oy = obs_y - py;
      bx = seg_ex - px; by = seg_ey - py;
      mx = seg_sx - px; my = seg_sy - py;
      ex = seg_ex - seg_sx; ey = seg_ey - seg_sy;
      c = '0;
      if (ox * ox + oy * oy <= longint'(STOP_RADIUS_DEF) * STOP_RADIUS_DEF) begin
         c.path_status = status_q;
         return c;
      end
      if (bx * bx + by * by < longint'(ARRIVE_RADIUS_DEF) * ARRIVE_RADIUS_DEF) begin
         if (pass_mode) begin
            status_q = ST_REACHING;
            c.speed_cmd = SPEED_PASS;
            c.direction_deg = last_dir;
            c.heading_out = p.heading;
            c.drive_enable = 1'b1;
            c.path_status = ST_REACHING;
         end else begin
            status_q = ST_STOPPED;
            c.path_status = ST_STOPPED;
         end
         return c;
      end
      an = mx; bn = my; dx = ex; dy = ey;
      // Degenerate axis: nudge the projection so the divisor never vanishes.
      if (ex == 0) begin
         an = mx + 1; dx = -1;
      end
      if (ey == 0) begin
         bn = my + 1; dy = -1;
      end
      dd = dx * dx + dy * dy;
      nn = an * dx + bn * dy;
      last_dir = aim_heading(dd * (mx + bx) - nn * ex, dd * (my + by) - nn * ey);
      status_q = ST_MOVING;
      c.speed_cmd = SPEED_CRUISE;
      c.direction_deg = last_dir;
      c.heading_out = p.heading;
      c.drive_enable = 1'b1;
      c.path_status = ST_MOVING;
      return c;
   endfunction

   // Driver: offers queued positions; predicts at each accepted transfer.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_commands.push_back(steer({req_if.pos_x, req_if.pos_y, req_if.heading}));
            void'(pending_positions.pop_front());
         end
         if (req_if.valid && !req_if.ready) begin
            // Hold the offer until it is taken.
         end else if (pending_positions.size() > 0 && (drive_calm || $urandom_range(99) >= 7))
               begin
            req_if.valid <= 1'b1;
            req_if.pos_x <= pending_positions[0].pos_x;
            req_if.pos_y <= pending_positions[0].pos_y;
            req_if.heading <= pending_positions[0].heading;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: back-pressure and field-by-field comparison.
   always @(posedge clock) begin
      command_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            commands_seen++;
            if (expected_commands.size() == 0) begin
               $display("unexpected command %0d", commands_seen);
               error_count++;
            end else begin
               want = expected_commands.pop_front();
               if (rsp_if.speed_cmd !== want.speed_cmd)
                  report_mismatch("speed_cmd", int'(rsp_if.speed_cmd), int'(want.speed_cmd));
               if (rsp_if.direction_deg !== want.direction_deg)
                  report_mismatch("direction_deg", int'(rsp_if.direction_deg),
                                  int'(want.direction_deg));
               if (rsp_if.heading_out !== want.heading_out)
                  report_mismatch("heading_out", int'(rsp_if.heading_out),
                                  int'(want.heading_out));
               if (rsp_if.drive_enable !== want.drive_enable)
                  report_mismatch("drive_enable", int'(rsp_if.drive_enable),
                                  int'(want.drive_enable));
               if (rsp_if.path_status !== want.path_status)
                  report_mismatch("path_status", int'(rsp_if.path_status),
                                  int'(want.path_status));
            end
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= drive_calm || $urandom_range(99) >= 7;
         end
      end
   end

   // Watchdog over cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input longint value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_START_X:    seg_sx = longint'(signed'(value[15:0]));
         CSR_START_Y:    seg_sy = longint'(signed'(value[15:0]));
         CSR_END_X:      seg_ex = longint'(signed'(value[15:0]));
         CSR_END_Y:      seg_ey = longint'(signed'(value[15:0]));
         CSR_PASS:       pass_mode = value[0];
         CSR_OBSTACLE_X: obs_x = longint'(signed'(value[15:0]));
         CSR_OBSTACLE_Y: obs_y = longint'(signed'(value[15:0]));
         default: ;
      endcase
   endtask

   task automatic setup_segment(input longint sx, input longint sy, input longint ex,
                                input longint ey, input bit pass, input longint ox,
                                input longint oy);
      write_register(CSR_START_X, sx);
      write_register(CSR_START_Y, sy);
      write_register(CSR_END_X, ex);
      write_register(CSR_END_Y, ey);
      write_register(CSR_PASS, pass);
      write_register(CSR_OBSTACLE_X, ox);
      write_register(CSR_OBSTACLE_Y, oy);
   endtask

   task automatic queue_position(input longint x, input longint y, input int hd);
      position_type p;
      p.pos_x = x[15:0];
      p.pos_y = y[15:0];
      p.heading = hd[8:0];
      pending_positions.push_back(p);
   endtask

   task automatic drain;
      wait (pending_positions.size() == 0 && !req_if.valid && expected_commands.size() == 0);
      repeat (800) @(posedge clock);
   endtask

   function automatic longint near_value(longint base, int spread);
      longint v;
      v = base + $signed($urandom_range(2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v;
   endfunction

   // A phase of random positions biased toward the segment, its end and the obstacle.
   task automatic random_phase(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(9);
         if (pick < 2) queue_position(near_value(seg_ex, 150), near_value(seg_ey, 150),
                                      $urandom_range(511));
         else if (pick < 3) queue_position(near_value(obs_x, 500), near_value(obs_y, 500),
                                           $urandom_range(360));
         else if (pick < 7) queue_position(near_value((seg_sx + seg_ex) / 2, 3000),
                                           near_value((seg_sy + seg_ey) / 2, 3000),
                                           $urandom_range(360));
         else queue_position($signed(16'($urandom)), $signed(16'($urandom)),
                             $urandom_range(511));
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.pos_x = '0;
      req_if.pos_y = '0;
      req_if.heading = '0;
      rsp_if.ready = 1'b0;
      error_count = 0;
      commands_seen = 0;
      idle_cycles = 0;
      drive_calm = 1'b0;
      hold_off_cycles = 0;
      seg_sx = 0; seg_sy = 0; seg_ex = 0; seg_ey = 0;
      obs_x = 2643; obs_y = 2643;
      pass_mode = 1'b0;
      last_dir = '0;
      status_q = ST_MOVING;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings, extremes, obstacle, end in both modes, axes.
      queue_position(0, 0, 0);
      queue_position(2643, 2643, 360);
      queue_position(2643 + 400, 2643, 7);
      queue_position(-32768, -32768, 511);
      queue_position(32767, 32767, 361);
      queue_position(5000, 0, 90);
      queue_position(0, 5000, 45);
      queue_position(-5000, 3, 12);
      queue_position(1, -5000, 300);
      drain();
      setup_segment(-1000, -1000, 1000, 1000, 1'b1, -20000, 20000);
      queue_position(0, 0, 10);
      queue_position(1000, 1050, 20);
      queue_position(990, 999, 30);
      queue_position(2000, 0, 40);
      queue_position(-20000, 20399, 50);
      queue_position(-20000, 20401, 60);
      queue_position(1000, 1099, 70);
      queue_position(1000, 1100, 80);
      drain();
      setup_segment(-32768, 32767, 32767, -32768, 1'b0, 32767, 32767);
      queue_position(-32768, -32768, 1);
      queue_position(32767, -32700, 2);
      queue_position(32767, 32767, 3);
      queue_position(0, 0, 4);
      drain();

      // Random phases under varied settings, with a long stall of the receiver.
      // Phases four and five use a segment with no extent along one axis.
      for (int phase = 0; phase < 10; phase++) begin
         longint sx_pick, sy_pick;
         sx_pick = $signed(16'($urandom_range(65535))) / (phase % 3 == 0 ? 1 : 8);
         sy_pick = $signed(16'($urandom_range(65535))) / (phase % 3 == 0 ? 1 : 8);
         setup_segment(sx_pick, sy_pick,
                       phase == 4 ? sx_pick : $signed(16'($urandom_range(65535))) / 8,
                       phase == 5 ? sy_pick : $signed(16'($urandom_range(65535))) / 8,
                       $urandom_range(1), $signed(16'($urandom_range(65535))) / 8,
                       $signed(16'($urandom_range(65535))) / 8);
         drive_calm = (phase == 2);
         if (phase == 6) hold_off_cycles = 3000;
         random_phase(100);
         drain();
      end
      drive_calm = 1'b0;

      $display("covered %0d drive commands over directed cases and ten random settings",
               commands_seen);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

@@ filelist.f @@
rtl/sps_pkg.sv
rtl/sps_if.sv
rtl/sps_serial_mul.sv
rtl/segment_path_steering_unit.sv
tb/segment_path_steering_unit_test.sv
